>>> rtl/gmc_pkg.sv
package gmc_pkg;

    // Event kinds carried by an input item.
    localparam logic [1:0] KIND_PRESS    = 2'd0;
    localparam logic [1:0] KIND_RELEASE  = 2'd1;
    localparam logic [1:0] KIND_CONFLICT = 2'd2;
    localparam logic [1:0] KIND_OTHER    = 2'd3;

    // Button codes. Codes six and seven match no rule.
    localparam logic [2:0] BTN_DRV_OPEN  = 3'd0;
    localparam logic [2:0] BTN_DRV_CLOSE = 3'd1;
    localparam logic [2:0] BTN_SEC_OPEN  = 3'd2;
    localparam logic [2:0] BTN_SEC_CLOSE = 3'd3;
    localparam logic [2:0] BTN_LIM_OPEN  = 3'd4;
    localparam logic [2:0] BTN_LIM_CLOSE = 3'd5;

    // Gate state codes as seen on the result channel.
    localparam logic [2:0] CODE_IDLE_CLOSED = 3'd0;
    localparam logic [2:0] CODE_OPENING     = 3'd1;
    localparam logic [2:0] CODE_IDLE_OPEN   = 3'd2;
    localparam logic [2:0] CODE_CLOSING     = 3'd3;
    localparam logic [2:0] CODE_STOPPED     = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE_CLOSED = 5'b00001,
        ST_OPENING     = 5'b00010,
        ST_IDLE_OPEN   = 5'b00100,
        ST_CLOSING     = 5'b01000,
        ST_STOPPED     = 5'b10000
    } gate_state_t;

    // Next state and security flag handed from the transition logic.
    typedef struct packed {
        gate_state_t state;
        logic        sec;
    } gmc_next_t;

    function automatic logic [2:0] state_code(input gate_state_t st);
        logic [2:0] code;
        code = CODE_IDLE_CLOSED;
        unique case (st)
            ST_IDLE_CLOSED: code = CODE_IDLE_CLOSED;
            ST_OPENING:     code = CODE_OPENING;
            ST_IDLE_OPEN:   code = CODE_IDLE_OPEN;
            ST_CLOSING:     code = CODE_CLOSING;
            ST_STOPPED:     code = CODE_STOPPED;
            default:        code = CODE_IDLE_CLOSED;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/gmc_fsm.sv
module gmc_fsm
    import gmc_pkg::*;
(
    input  gate_state_t state,
    input  logic        sec,
    input  logic [1:0]  kind,
    input  logic [2:0]  button,
    output gmc_next_t   nxt
);

    // Direction-dependent buttons and targets while the gate is moving.
    logic [2:0]  fwd_drv;
    logic [2:0]  fwd_sec;
    logic [2:0]  limit_btn;
    logic [2:0]  rev_btn;
    gate_state_t at_limit;
    gate_state_t rev_state;
    logic        press;

    assign press = (kind == KIND_PRESS);

    always_comb begin
        if (state == ST_CLOSING) begin
            fwd_drv   = BTN_DRV_CLOSE;
            fwd_sec   = BTN_SEC_CLOSE;
            limit_btn = BTN_LIM_CLOSE;
            at_limit  = ST_IDLE_CLOSED;
            rev_btn   = BTN_SEC_OPEN;
            rev_state = ST_OPENING;
        end else begin
            fwd_drv   = BTN_DRV_OPEN;
            fwd_sec   = BTN_SEC_OPEN;
            limit_btn = BTN_LIM_OPEN;
            at_limit  = ST_IDLE_OPEN;
            rev_btn   = BTN_SEC_CLOSE;
            rev_state = ST_CLOSING;
        end
    end

    always_comb begin
        nxt.state = state;
        nxt.sec   = sec;
        unique case (state)
            ST_OPENING, ST_CLOSING: begin
                if (kind == KIND_CONFLICT) begin
                    // A security movement only yields to the security open button.
                    if (!sec || button == BTN_SEC_OPEN) begin
                        nxt.state = ST_STOPPED;
                    end
                end else if (kind == KIND_RELEASE) begin
                    if (sec) begin
                        if (button == fwd_sec) begin
                            nxt.state = ST_STOPPED;
                        end
                    end else if (button == fwd_drv || button == fwd_sec) begin
                        nxt.state = ST_STOPPED;
                    end
                end else if (press) begin
                    if (button == limit_btn) begin
                        nxt.state = at_limit;
                    end else if (button == rev_btn) begin
                        nxt.state = rev_state;
                        nxt.sec   = 1'b1;
                    end
                end
            end
            ST_IDLE_CLOSED: begin
                if (press && button == BTN_DRV_OPEN) begin
                    nxt.state = ST_OPENING;
                    nxt.sec   = 1'b0;
                end else if (press && button == BTN_SEC_OPEN) begin
                    nxt.state = ST_OPENING;
                    nxt.sec   = 1'b1;
                end
            end
            ST_IDLE_OPEN: begin
                if (press && button == BTN_DRV_CLOSE) begin
                    nxt.state = ST_CLOSING;
                    nxt.sec   = 1'b0;
                end else if (press && button == BTN_SEC_CLOSE) begin
                    nxt.state = ST_CLOSING;
                    nxt.sec   = 1'b1;
                end
            end
            ST_STOPPED: begin
                if (press) begin
                    if (button == BTN_DRV_OPEN) begin
                        nxt.state = ST_OPENING;
                        nxt.sec   = 1'b0;
                    end else if (button == BTN_SEC_OPEN) begin
                        nxt.state = ST_OPENING;
                        nxt.sec   = 1'b1;
                    end else if (button == BTN_DRV_CLOSE) begin
                        nxt.state = ST_CLOSING;
                        nxt.sec   = 1'b0;
                    end else if (button == BTN_SEC_CLOSE) begin
                        nxt.state = ST_CLOSING;
                        nxt.sec   = 1'b1;
                    end
                end
            end
            default: begin
                nxt.state = state;
                nxt.sec   = sec;
            end
        endcase
    end

endmodule

>>> rtl/gate_motion_controller.sv
// The result item for an accepted event is valid the cycle after.
// Throughput: one item per cycle while the consumer takes each item, set by the single
// result register, which is refilled in the same cycle that its item is taken.
// Reset (aresetn low, synchronous): the gate is idle closed, the security flag is
// clear, and no result item is pending.
module gate_motion_controller
    import gmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [2:0] s_button,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_gate_state,
    output logic       m_security_active,
    output logic       m_lamp_green,
    output logic       m_lamp_red
);

    // The gate state and security flag persist between items. The result
    // register holds the reported copy of them until the consumer takes it.
    gate_state_t state_reg;
    logic        sec_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [2:0]  gate_code_reg;
    logic        sec_out_reg;
    logic        green_reg;
    logic        red_reg;

    gmc_next_t   nxt;
    logic        s_fire;

    // An item can enter whenever the result register is empty or is being
    // emptied in this same cycle, so a stalled consumer stalls the producer
    // but an active one sees one item per cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    gmc_fsm u_fsm (
        .state  (state_reg),
        .sec    (sec_reg),
        .kind   (s_kind),
        .button (s_button),
        .nxt    (nxt)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE_CLOSED;
            sec_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                state_reg <= nxt.state;
                sec_reg   <= nxt.sec;
            end
        end
    end

    // Result payload: loaded only on an accepted item, so it holds while stalled.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            gate_code_reg <= state_code(nxt.state);
            sec_out_reg   <= nxt.sec;
            green_reg     <= (nxt.state == ST_OPENING);
            red_reg       <= (nxt.state == ST_CLOSING);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_gate_state      = gate_code_reg;
    assign m_security_active = sec_out_reg;
    assign m_lamp_green      = green_reg;
    assign m_lamp_red        = red_reg;

    // The state register is always exactly one of the five one-hot codes.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("gate state register is not one-hot");

    // The gate state only moves when an item is accepted.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(state_reg) && $stable(sec_reg))
        else $error("gate state changed without an accepted item");

    // The reported result matches the stored state after every accepted item.
    a_result_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid && m_gate_state == state_code(state_reg)
                   && m_security_active == sec_reg)
        else $error("result item disagrees with the gate state");

    // The lamps follow the reported state and are never lit together.
    a_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_lamp_green && m_lamp_red)
                    && (m_lamp_green == (m_gate_state == CODE_OPENING))
                    && (m_lamp_red == (m_gate_state == CODE_CLOSING)))
        else $error("lamp drives disagree with the gate state");

endmodule
